@@ design/pald_pkg.sv @@
// ----------------------------------------------------------------------------
// pald_pkg
// shared types, codes and defaults of the parallel addressable led driver
// ----------------------------------------------------------------------------
package pald_pkg;

  localparam int IDX_W        = 12;
  localparam int LANE_W       = 4;
  localparam int COLOR_W      = 24;
  localparam int PIN_W        = 16;
  localparam int STATUS_W     = 2;
  localparam int BITS_PER_LED = 24;
  localparam int BITPOS_W     = 5;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int TICK_W       = 16;
  localparam int LATCH_W      = 24;

  // default geometry
  localparam int LANES_DEF         = 16;
  localparam int LEDS_PER_LANE_DEF = 256;
  localparam int ROW_LENGTH_DEF    = 64;

  // fixed-point reciprocal used to split a global index
  localparam int MAP_SHIFT = 24;

  localparam logic [TICK_W-1:0]  BIT_PERIOD_RST = 16'd208;
  localparam logic [TICK_W-1:0]  ZERO_HIGH_RST  = 16'd20;
  localparam logic [TICK_W-1:0]  ONE_HIGH_RST   = 16'd140;
  localparam logic [LATCH_W-1:0] LATCH_RST      = 24'd8400;
  localparam logic [LATCH_W-1:0] LATCH_MAX      = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ACT_MAP  = 2'd0,
    ACT_LANE = 2'd1,
    ACT_SHOW = 2'd2,
    ACT_TICK = 2'd3
  } pald_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_BUSY  = 2'd1,
    STS_RANGE = 2'd2
  } pald_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD = 2'd0,
    CFG_ZERO_HIGH  = 2'd1,
    CFG_ONE_HIGH   = 2'd2,
    CFG_LATCH      = 2'd3
  } pald_cfg_e;

  typedef enum logic [1:0] {
    PIN_LOW  = 2'd0,
    PIN_DATA = 2'd1,
    PIN_HIGH = 2'd2
  } pald_pin_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } pald_state_e;

  typedef struct packed {
    logic [TICK_W-1:0]  bit_period;
    logic [TICK_W-1:0]  zero_high;
    logic [TICK_W-1:0]  one_high;
    logic [LATCH_W-1:0] latch_ticks;
  } pald_cfg_t;

  // per-beat outcome of the frame sequencer
  typedef struct packed {
    pald_pin_e           pin_class;
    logic [BITPOS_W-1:0] bitpos;
    logic                rd_a;
    logic                busy;
    logic                show_rej;
  } pald_seq_t;

endpackage

@@ design/parallel_addressable_led_driver.sv @@
// ----------------------------------------------------------------------------
// parallel_addressable_led_driver
// multi-lane one-wire led driver with a double-buffered bit-plane store
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | in_valid_i / in_ready_o   | action, lane, pixel_index, rgb
//  out     | output    | out_valid_o / out_ready_i | pins, busy_res, status
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one beat per clock while out_ready_i is high; a beat passes the stage register,
//  then the output register. the limit is the single write port of each plane
//  store, one pixel per cycle. after reset a clearing pass zeroes both stores,
//  in_ready_o stays low during it; configuration beats are always taken
//  a stalled result holds in the output register while one more beat waits
//  in the pipeline stage; a further beat is taken once the result leaves
// ----------------------------------------------------------------------------
module parallel_addressable_led_driver import pald_pkg::*; #(
  parameter int LANES         = LANES_DEF,
  parameter int LEDS_PER_LANE = LEDS_PER_LANE_DEF,
  parameter int ROW_LENGTH    = ROW_LENGTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            action_i,
  input  logic [LANE_W-1:0]     lane_i,
  input  logic [IDX_W-1:0]      pixel_index_i,
  input  logic [COLOR_W-1:0]    rgb_color_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIN_W-1:0]      pins_o,
  output logic                  busy_res_o,
  output logic [STATUS_W-1:0]   status_o,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW      = (LEDS_PER_LANE > 1) ? $clog2(LEDS_PER_LANE) : 1;
  // reciprocal of LEDS_PER_LANE, exact for every 12-bit index
  localparam int MapMult = ((1 << MAP_SHIFT) + LEDS_PER_LANE - 1) / LEDS_PER_LANE;
  localparam int ProdW   = IDX_W + MAP_SHIFT + 1;
  localparam logic [PIN_W-1:0] LaneMask = PIN_W'((1 << LANES) - 1);

  // ---------------------------------------------------------------- config
  pald_cfg_t   cfg_q;
  pald_cfg_e   cfg_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_sel     = pald_cfg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period  <= BIT_PERIOD_RST;
      cfg_q.zero_high   <= ZERO_HIGH_RST;
      cfg_q.one_high    <= ONE_HIGH_RST;
      cfg_q.latch_ticks <= LATCH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_sel)
        CFG_BIT_PERIOD: cfg_q.bit_period  <= cfg_data_i[TICK_W-1:0];
        CFG_ZERO_HIGH:  cfg_q.zero_high   <= cfg_data_i[TICK_W-1:0];
        CFG_ONE_HIGH:   cfg_q.one_high    <= cfg_data_i[TICK_W-1:0];
        CFG_LATCH:      cfg_q.latch_ticks <= cfg_data_i[LATCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------- clear pass
  pald_state_e state_q, state_d;
  logic [AW-1:0] clr_addr_q;
  logic          clearing;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == AW'(LEDS_PER_LANE - 1)) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_CLEAR: clearing = 1'b1;
      default:  clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // ------------------------------------------------------- handshake flow
  logic s1_valid_q;
  logic out_valid_q;
  logic adv;      // output register free this cycle
  logic in_acc;
  logic s1_go;    // stage beat moves into the output register

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !clearing && (!s1_valid_q || adv);
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_go      = s1_valid_q && adv;

  // ------------------------------------------------------ accept stage
  pald_action_e in_act;
  pald_seq_t    seq;
  logic         draw_sel;
  logic [AW-1:0] send_row;
  logic [ProdW-1:0] map_prod;

  assign in_act   = pald_action_e'(action_i);
  // global index times reciprocal gives the lane of a mapped write
  assign map_prod = ProdW'(pixel_index_i) * ProdW'(MapMult);

  pald_frame_seq #(
    .LEDS_PER_LANE (LEDS_PER_LANE),
    .AW            (AW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .act_i      (in_act),
    .cfg_i      (cfg_q),
    .seq_o      (seq),
    .draw_sel_o (draw_sel),
    .row_o      (send_row)
  );

  pald_action_e        s1_act_q;
  logic [LANE_W-1:0]   s1_lane_q;
  logic [IDX_W-1:0]    s1_idx_q;
  logic [IDX_W-1:0]    s1_quot_q;
  logic [COLOR_W-1:0]  s1_grb_q;
  logic                s1_draw_q;  // 1: pixel goes to store a
  pald_seq_t           s1_seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_act_q  <= in_act;
      s1_lane_q <= lane_i;
      s1_idx_q  <= pixel_index_i;
      s1_quot_q <= map_prod[MAP_SHIFT +: IDX_W];
      // rgb reordered to grb
      s1_grb_q  <= {rgb_color_i[15:8], rgb_color_i[23:16], rgb_color_i[7:0]};
      s1_draw_q <= draw_sel;
      s1_seq_q  <= seq;
    end
  end

  // ------------------------------------------------------- pixel write
  logic            map_ok;
  logic [LANE_W-1:0] map_lane;
  logic [AW-1:0]   map_addr;
  logic            is_write;
  logic            wr_en;
  logic [LANES-1:0] lane_oh;

  pald_pixel_map #(
    .LANES         (LANES),
    .LEDS_PER_LANE (LEDS_PER_LANE),
    .ROW_LENGTH    (ROW_LENGTH),
    .AW            (AW)
  ) u_map (
    .is_lane_i (s1_act_q == ACT_LANE),
    .lane_i    (s1_lane_q),
    .idx_i     (s1_idx_q),
    .quot_i    (s1_quot_q),
    .ok_o      (map_ok),
    .lane_o    (map_lane),
    .addr_o    (map_addr)
  );

  assign is_write = (s1_act_q == ACT_MAP) || (s1_act_q == ACT_LANE);
  // the write lands before any later show's first tick can read the store
  assign wr_en    = s1_go && is_write && map_ok;
  assign lane_oh  = LANES'(1) << map_lane;

  // ------------------------------------------------------- plane stores
  logic [LANES-1:0]            we_a, we_b;
  logic [AW-1:0]               waddr;
  logic [BITS_PER_LED-1:0]     wdata;
  logic                        rd_en;
  logic [LANES-1:0][BITS_PER_LED-1:0] rdata_a, rdata_b, rdata;

  always_comb begin
    if (clearing) begin
      we_a  = '1;
      we_b  = '1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we_a  = (wr_en && s1_draw_q)  ? lane_oh : '0;
      we_b  = (wr_en && !s1_draw_q) ? lane_oh : '0;
      waddr = map_addr;
      wdata = s1_grb_q;
    end
  end

  // both stores read on every tick beat; the stage picks the one being sent
  assign rd_en = in_acc && (in_act == ACT_TICK);

  pald_plane_mem #(
    .LANES (LANES),
    .DEPTH (LEDS_PER_LANE),
    .AW    (AW)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (send_row),
    .rdata_o (rdata_a)
  );

  pald_plane_mem #(
    .LANES (LANES),
    .DEPTH (LEDS_PER_LANE),
    .AW    (AW)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (send_row),
    .rdata_o (rdata_b)
  );

  assign rdata = s1_seq_q.rd_a ? rdata_a : rdata_b;

  // ------------------------------------------------------- result build
  logic [BITPOS_W-1:0] bit_sel;
  logic [PIN_W-1:0]    data_pins;
  logic [PIN_W-1:0]    tick_pins;
  logic [PIN_W-1:0]    pin_level_q;
  pald_status_e        status;

  assign bit_sel = BITPOS_W'(BITS_PER_LED - 1) - s1_seq_q.bitpos;

  // lanes whose current bit is one stay high through the data window
  always_comb begin
    data_pins = '0;
    for (int l = 0; l < LANES; l++) begin
      data_pins[l] = rdata[l][bit_sel];
    end
  end

  always_comb begin
    case (s1_seq_q.pin_class)
      PIN_HIGH: tick_pins = LaneMask;
      PIN_DATA: tick_pins = data_pins;
      default:  tick_pins = '0;
    endcase
  end

  always_comb begin
    case (s1_act_q)
      ACT_MAP, ACT_LANE: status = map_ok ? STS_OK : STS_RANGE;
      ACT_SHOW:          status = s1_seq_q.show_rej ? STS_BUSY : STS_OK;
      default:           status = STS_OK;
    endcase
  end

  logic [PIN_W-1:0]    pins_q;
  logic                busy_q;
  logic [STATUS_W-1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pin_level_q <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      // pins keep their level across non-tick beats
      if (s1_go && (s1_act_q == ACT_TICK)) begin
        pin_level_q <= tick_pins;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      pins_q   <= (s1_act_q == ACT_TICK) ? tick_pins : pin_level_q;
      busy_q   <= s1_seq_q.busy;
      status_q <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pins_o      = pins_q;
  assign busy_res_o  = busy_q;
  assign status_o    = status_q;

endmodule

@@ design/pald_plane_mem.sv @@
// ----------------------------------------------------------------------------
// pald_plane_mem
// one bit-plane store: a row per led offset, 24 grb bits per lane, lane enables
// ----------------------------------------------------------------------------
module pald_plane_mem import pald_pkg::*; #(
  parameter int LANES = LANES_DEF,
  parameter int DEPTH = LEDS_PER_LANE_DEF,
  parameter int AW    = 8
) (
  input  logic                                 clk_i,
  input  logic [LANES-1:0]                     we_i,
  input  logic [AW-1:0]                        waddr_i,
  input  logic [BITS_PER_LED-1:0]              wdata_i,
  input  logic                                 re_i,
  input  logic [AW-1:0]                        raddr_i,
  output logic [LANES-1:0][BITS_PER_LED-1:0]   rdata_o
);

  logic [LANES-1:0][BITS_PER_LED-1:0] mem [DEPTH];
  logic [LANES-1:0][BITS_PER_LED-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (we_i[l]) begin
        mem[waddr_i][l] <= wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pald_pixel_map.sv @@
// ----------------------------------------------------------------------------
// pald_pixel_map
// turns a pixel write into a lane, a row address and a range check
// ----------------------------------------------------------------------------
module pald_pixel_map import pald_pkg::*; #(
  parameter int LANES         = LANES_DEF,
  parameter int LEDS_PER_LANE = LEDS_PER_LANE_DEF,
  parameter int ROW_LENGTH    = ROW_LENGTH_DEF,
  parameter int AW            = 8
) (
  input  logic              is_lane_i,
  input  logic [LANE_W-1:0] lane_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [IDX_W-1:0]  quot_i,
  output logic              ok_o,
  output logic [LANE_W-1:0] lane_o,
  output logic [AW-1:0]     addr_o
);

  localparam int Row2      = 2 * ROW_LENGTH;
  localparam int RowMirror = 3 * ROW_LENGTH - 1;

  logic [2*IDX_W-1:0] back;
  logic [IDX_W-1:0]   rem;
  logic               in_row1;
  logic [IDX_W:0]     mirrored;
  logic [IDX_W-1:0]   map_off;
  logic [IDX_W-1:0]   offset;
  logic               lane_ok;

  // remainder of the global index, then second row mirrored
  assign back     = (2*IDX_W)'(quot_i) * (2*IDX_W)'(LEDS_PER_LANE);
  assign rem      = idx_i - back[IDX_W-1:0];
  assign in_row1  = ({1'b0, rem} >= (IDX_W+1)'(ROW_LENGTH)) &&
                    ({1'b0, rem} <  (IDX_W+1)'(Row2));
  assign mirrored = (IDX_W+1)'(RowMirror) - {1'b0, rem};
  assign map_off  = in_row1 ? mirrored[IDX_W-1:0] : rem;

  assign offset  = is_lane_i ? idx_i : map_off;
  assign lane_ok = is_lane_i ? ({1'b0, lane_i} < (LANE_W+1)'(LANES))
                             : (quot_i < IDX_W'(LANES));
  assign ok_o    = lane_ok && ({1'b0, offset} < (IDX_W+1)'(LEDS_PER_LANE));
  assign lane_o  = is_lane_i ? lane_i : quot_i[LANE_W-1:0];
  assign addr_o  = offset[AW-1:0];

endmodule

@@ design/pald_frame_seq.sv @@
// ----------------------------------------------------------------------------
// pald_frame_seq
// frame sequencer: buffer swap, slot and tick counters, latch wait
// ----------------------------------------------------------------------------
module pald_frame_seq import pald_pkg::*; #(
  parameter int LEDS_PER_LANE = LEDS_PER_LANE_DEF,
  parameter int AW            = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         acc_i,
  input  pald_action_e act_i,
  input  pald_cfg_t    cfg_i,
  output pald_seq_t    seq_o,
  output logic         draw_sel_o,
  output logic [AW-1:0] row_o
);

  logic                draw_q, draw_d;
  logic                sending_q, sending_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [BITPOS_W-1:0] bit_q, bit_d;
  logic [AW-1:0]       row_q, row_d;
  logic [LATCH_W-1:0]  latch_q, latch_d;
  logic                busy_now;

  assign busy_now = sending_q || (latch_q < cfg_i.latch_ticks);

  always_comb begin
    draw_d         = draw_q;
    sending_d      = sending_q;
    tick_d         = tick_q;
    bit_d          = bit_q;
    row_d          = row_q;
    latch_d        = latch_q;
    seq_o.pin_class = PIN_LOW;
    seq_o.bitpos   = bit_q;
    seq_o.rd_a     = ~draw_q;
    seq_o.show_rej = 1'b0;
    case (act_i)
      ACT_SHOW: begin
        if (busy_now) begin
          seq_o.show_rej = 1'b1;
        end else begin
          draw_d    = ~draw_q;
          sending_d = 1'b1;
          tick_d    = '0;
          bit_d     = '0;
          row_d     = '0;
        end
      end
      ACT_TICK: begin
        if (sending_q) begin
          if (tick_q >= cfg_i.one_high) begin
            seq_o.pin_class = PIN_LOW;
          end else if (tick_q >= cfg_i.zero_high) begin
            seq_o.pin_class = PIN_DATA;
          end else begin
            seq_o.pin_class = PIN_HIGH;
          end
          if (tick_q >= cfg_i.bit_period) begin
            tick_d = '0;
            if (bit_q == BITPOS_W'(BITS_PER_LED - 1)) begin
              bit_d = '0;
              if (row_q == AW'(LEDS_PER_LANE - 1)) begin
                row_d     = '0;
                sending_d = 1'b0;
                latch_d   = '0;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              bit_d = bit_q + 1'b1;
            end
          end else begin
            tick_d = tick_q + 1'b1;
          end
        end else if (latch_q != LATCH_MAX) begin
          latch_d = latch_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
    seq_o.busy = sending_d || (latch_d < cfg_i.latch_ticks);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_q    <= 1'b0;
      sending_q <= 1'b0;
      tick_q    <= '0;
      bit_q     <= '0;
      row_q     <= '0;
      latch_q   <= LATCH_MAX;
    end else if (acc_i) begin
      draw_q    <= draw_d;
      sending_q <= sending_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      row_q     <= row_d;
      latch_q   <= latch_d;
    end
  end

  assign draw_sel_o = draw_q;
  assign row_o      = row_q;

endmodule
